[rtl/core/tfn_pkg.sv]
package tfn_pkg;

  // The largest scaled cross magnitude keeps its top set bit at bit 30.
  localparam int C_BITS    = 31;
  localparam int SQ_BITS   = 2 * C_BITS;
  localparam int SUM_BITS  = 64;
  localparam int ROOT_BITS = 32;
  localparam int DEN_BITS  = ROOT_BITS + 1;

endpackage

[rtl/core/tfn_tri_if.sv]
interface tfn_tri_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x;
  logic signed [COORD_BITS-1:0] v0_y;
  logic signed [COORD_BITS-1:0] v0_z;
  logic signed [COORD_BITS-1:0] v1_x;
  logic signed [COORD_BITS-1:0] v1_y;
  logic signed [COORD_BITS-1:0] v1_z;
  logic signed [COORD_BITS-1:0] v2_x;
  logic signed [COORD_BITS-1:0] v2_y;
  logic signed [COORD_BITS-1:0] v2_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    output ready
  );
endinterface

[rtl/core/tfn_norm_if.sv]
interface tfn_norm_if #(
  parameter int NORMAL_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [NORMAL_BITS-1:0] normal_x;
  logic signed [NORMAL_BITS-1:0] normal_y;
  logic signed [NORMAL_BITS-1:0] normal_z;
  logic                          degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

[rtl/core/triangle_face_normal_unit.sv]
// Channel    Modport           Transfer carries
// tri_in     tfn_tri_if.sink   three vertices, signed Q12.12 by default
// norm_out   tfn_norm_if.source unit normal in signed Q1.14, degenerate flag
//
// One triangle enters per clock while no stalled output holds up the pipeline,
// which runs through the 32-stage square root and the one-bit-per-stage dividers.
// Reset (rst, synchronous) clears only the stage valid bits.
// Each stage holds its item until the next stage frees up, so bubbles
// close up under a stall and no transfer is lost or repeated.
module triangle_face_normal_unit #(
  parameter int COORD_BITS  = 24,
  parameter int NORMAL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  tfn_tri_if.sink           tri_in,
  tfn_norm_if.source        norm_out
);

  localparam int CB   = tfn_pkg::C_BITS;
  localparam int EW   = COORD_BITS + 1;
  localparam int PW   = 2 * EW;
  localparam int XW   = PW + 1;
  localparam int LW   = $clog2(XW + 1);
  localparam int FB   = NORMAL_BITS - 2;
  localparam int QW   = FB + 1;
  localparam int NW   = FB + 34;
  localparam int RB   = tfn_pkg::ROOT_BITS;
  localparam int SQ0  = 8;
  localparam int DV0  = SQ0 + RB;
  localparam int OUTS = DV0 + QW;
  localparam int NS   = OUTS + 1;

  // Stage valid bits and the ripple of stage enables.
  logic [NS-1:0] v;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = norm_out.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign tri_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= tri_in.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 0: edges.
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1[0] <= EW'(tri_in.v1_x) - EW'(tri_in.v0_x);
      e1[1] <= EW'(tri_in.v1_y) - EW'(tri_in.v0_y);
      e1[2] <= EW'(tri_in.v1_z) - EW'(tri_in.v0_z);
      e2[0] <= EW'(tri_in.v2_x) - EW'(tri_in.v0_x);
      e2[1] <= EW'(tri_in.v2_y) - EW'(tri_in.v0_y);
      e2[2] <= EW'(tri_in.v2_z) - EW'(tri_in.v0_z);
    end
  end

  // Stage 1: the six products of edge2 x edge1.
  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pa[0] <= PW'(e2[1]) * PW'(e1[2]);
      pb[0] <= PW'(e2[2]) * PW'(e1[1]);
      pa[1] <= PW'(e2[2]) * PW'(e1[0]);
      pb[1] <= PW'(e2[0]) * PW'(e1[2]);
      pa[2] <= PW'(e2[0]) * PW'(e1[1]);
      pb[2] <= PW'(e2[1]) * PW'(e1[0]);
    end
  end

  // Stage 2: cross components.
  logic signed [XW-1:0] cr [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        cr[i] <= XW'(pa[i]) - XW'(pb[i]);
      end
    end
  end

  // Stage 3: sign and magnitude.
  logic [XW-1:0] mg3 [3];
  logic [2:0]    ng3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        ng3[i] <= cr[i][XW-1];
        mg3[i] <= cr[i][XW-1] ? XW'(-cr[i]) : XW'(cr[i]);
      end
    end
  end

  // Stage 4: bit length of the largest magnitude.
  logic [XW-1:0] mg4 [3];
  logic [2:0]    ng4;
  logic [LW-1:0] len4;
  logic [XW-1:0] any_bits;
  logic [LW-1:0] len_next;

  always_comb begin
    any_bits = mg3[0] | mg3[1] | mg3[2];
    len_next = '0;
    for (int b = 0; b < XW; b++) begin
      if (any_bits[b]) begin
        len_next = LW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mg4  <= mg3;
      ng4  <= ng3;
      len4 <= len_next;
    end
  end

  // Stage 5: scale so that the top bit lands at bit 30.
  logic [CB-1:0] c5 [3];
  logic [2:0]    ng5;
  logic          dg5;
  logic [XW+CB-1:0] sh5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh5[i] = {mg4[i], {CB{1'b0}}} >> len4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        c5[i] <= sh5[i][CB-1:0];
      end
      ng5 <= ng4;
      dg5 <= (len4 == '0);
    end
  end

  // Stage 6: squares.
  logic [tfn_pkg::SQ_BITS-1:0] sq6 [3];
  logic [CB-1:0] c6 [3];
  logic [2:0]    ng6;
  logic          dg6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= tfn_pkg::SQ_BITS'(c5[i]) * tfn_pkg::SQ_BITS'(c5[i]);
      end
      c6  <= c5;
      ng6 <= ng5;
      dg6 <= dg5;
    end
  end

  // Stage 7: sum of squares.
  logic [tfn_pkg::SUM_BITS-1:0] s7;
  logic [CB-1:0] c7 [3];
  logic [2:0]    ng7;
  logic          dg7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7  <= tfn_pkg::SUM_BITS'(sq6[0]) + tfn_pkg::SUM_BITS'(sq6[1])
           + tfn_pkg::SUM_BITS'(sq6[2]);
      c7  <= c6;
      ng7 <= ng6;
      dg7 <= dg6;
    end
  end

  // Square root, one root bit per stage, most significant first.
  logic [tfn_pkg::SUM_BITS-1:0] sq_rem  [RB];
  logic [RB-1:0]                sq_root [RB];
  logic [CB-1:0]                sq_c    [RB][3];
  logic [2:0]                   sq_ng   [RB];
  logic                         sq_dg   [RB];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int BI = RB - 1 - j;
    logic [tfn_pkg::SUM_BITS-1:0] rem_in;
    logic [RB-1:0]                root_in;
    logic [CB-1:0]                c_in [3];
    logic [2:0]                   ng_in;
    logic                         dg_in;
    logic [tfn_pkg::SUM_BITS+1:0] delta;

    if (j == 0) begin : g_first
      assign rem_in  = s7;
      assign root_in = '0;
      assign c_in    = c7;
      assign ng_in   = ng7;
      assign dg_in   = dg7;
    end else begin : g_rest
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
      assign c_in    = sq_c[j-1];
      assign ng_in   = sq_ng[j-1];
      assign dg_in   = sq_dg[j-1];
    end

    // Growth of the square when this root bit is set.
    assign delta = ((tfn_pkg::SUM_BITS + 2)'(root_in) << (BI + 1))
                 + ((tfn_pkg::SUM_BITS + 2)'(1) << (2 * BI));

    always_ff @(posedge clk) begin
      if (en[SQ0 + j]) begin
        if ((tfn_pkg::SUM_BITS + 2)'(rem_in) >= delta) begin
          sq_rem[j]  <= rem_in - tfn_pkg::SUM_BITS'(delta);
          sq_root[j] <= root_in | (RB'(1) << BI);
        end else begin
          sq_rem[j]  <= rem_in;
          sq_root[j] <= root_in;
        end
        sq_c[j]  <= c_in;
        sq_ng[j] <= ng_in;
        sq_dg[j] <= dg_in;
      end
    end
  end

  // Rounded division c / R, one quotient bit per stage in three lanes.
  logic [NW-1:0]                dv_rem [QW][3];
  logic [QW-1:0]                dv_q   [QW][3];
  logic [tfn_pkg::DEN_BITS-1:0] dv_den [QW];
  logic [2:0]                   dv_ng  [QW];
  logic                         dv_dg  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int QB = FB - k;
    logic [NW-1:0]                rem_in [3];
    logic [QW-1:0]                q_in   [3];
    logic [tfn_pkg::DEN_BITS-1:0] den_in;
    logic [2:0]                   ng_in;
    logic                         dg_in;
    logic [NW-1:0]                sub;

    if (k == 0) begin : g_first
      // Numerator c * 2^(FB+1) + R over denominator 2R.
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = (NW'(sq_c[RB-1][i]) << (FB + 1)) + NW'(sq_root[RB-1]);
        assign q_in[i]   = '0;
      end
      assign den_in = {sq_root[RB-1], 1'b0};
      assign ng_in  = sq_ng[RB-1];
      assign dg_in  = sq_dg[RB-1];
    end else begin : g_rest
      assign rem_in = dv_rem[k-1];
      assign q_in   = dv_q[k-1];
      assign den_in = dv_den[k-1];
      assign ng_in  = dv_ng[k-1];
      assign dg_in  = dv_dg[k-1];
    end

    assign sub = NW'(den_in) << QB;

    always_ff @(posedge clk) begin
      if (en[DV0 + k]) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= sub) begin
            dv_rem[k][i] <= rem_in[i] - sub;
            dv_q[k][i]   <= q_in[i] | (QW'(1) << QB);
          end else begin
            dv_rem[k][i] <= rem_in[i];
            dv_q[k][i]   <= q_in[i];
          end
        end
        dv_den[k] <= den_in;
        dv_ng[k]  <= ng_in;
        dv_dg[k]  <= dg_in;
      end
    end
  end

  // Output register: apply signs, zero the normal of a flat triangle.
  logic signed [NORMAL_BITS-1:0] nrm [3];
  logic                          deg_out;
  logic [NORMAL_BITS-1:0]        mag_ext [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_ext[i] = NORMAL_BITS'(dv_q[QW-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_dg[QW-1]) begin
          nrm[i] <= '0;
        end else if (dv_ng[QW-1][i]) begin
          nrm[i] <= -mag_ext[i];
        end else begin
          nrm[i] <= mag_ext[i];
        end
      end
      deg_out <= dv_dg[QW-1];
    end
  end

  assign norm_out.valid      = v[OUTS];
  assign norm_out.normal_x   = nrm[0];
  assign norm_out.normal_y   = nrm[1];
  assign norm_out.normal_z   = nrm[2];
  assign norm_out.degenerate = deg_out;

endmodule

[rtl/core/tfn_checker.sv]
module tfn_checker #(
  parameter int NORMAL_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [NORMAL_BITS-1:0] normal_x,
  input logic signed [NORMAL_BITS-1:0] normal_y,
  input logic signed [NORMAL_BITS-1:0] normal_z,
  input logic                          degenerate
);

  localparam logic signed [NORMAL_BITS-1:0] ONE = NORMAL_BITS'(1) << (NORMAL_BITS - 2);

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // A flat triangle carries an all-zero normal.
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate result with nonzero normal");

  // A real triangle never yields an all-zero normal.
  a_nondeg_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
    else $error("zero normal without degenerate flag");

  // Components stay within plus and minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE
      && normal_y >= -ONE && normal_z <= ONE && normal_z >= -ONE)
    else $error("normal component out of range");

  // A result waiting for transfer holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
      && $stable(normal_z) && $stable(degenerate))
    else $error("stalled result changed");

endmodule

bind triangle_face_normal_unit tfn_checker #(.NORMAL_BITS(NORMAL_BITS)) u_tfn_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (norm_out.valid),
  .out_ready  (norm_out.ready),
  .normal_x   (norm_out.normal_x),
  .normal_y   (norm_out.normal_y),
  .normal_z   (norm_out.normal_z),
  .degenerate (norm_out.degenerate)
);

[dv/triangle_face_normal_unit_test.sv]
`timescale 1ns / 100ps

module triangle_face_normal_unit_test;

  localparam int COORD_BITS  = 24;
  localparam int NORMAL_BITS = 16;
  localparam int FRAC_BITS   = NORMAL_BITS - 2;
  localparam int LATENCY     = 41 + NORMAL_BITS - 2;
  localparam int RANDOM_TRIS = 1950;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [NORMAL_BITS-1:0] comp_t;

  typedef struct {
    coord_t v [9];
  } triangle_t;

  typedef struct {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  degenerate;
  } face_normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfn_tri_if  #(.COORD_BITS(COORD_BITS))   tri_in ();
  tfn_norm_if #(.NORMAL_BITS(NORMAL_BITS)) norm_out ();

  triangle_face_normal_unit #(
    .COORD_BITS (COORD_BITS),
    .NORMAL_BITS(NORMAL_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .tri_in  (tri_in.sink),
    .norm_out(norm_out.source)
  );

  always #10 clk = ~clk;

  triangle_t    pending_tris [$];
  face_normal_t expected_normals [$];
  int           fail_count = 0;
  int           cycle_count = 0;
  bit           stimulus_done = 1'b0;
  bit           hold_sender = 1'b0;

  // Integer square root by exhaustive bit trial.
  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      longint unsigned t;
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // Unit normal of edge2 x edge1, rounded to nearest in Q1.14.
  function automatic face_normal_t face_normal(triangle_t t);
    face_normal_t res;
    logic signed [COORD_BITS:0] e1 [3];
    logic signed [COORD_BITS:0] e2 [3];
    logic signed [2*COORD_BITS+3:0] cr [3];
    logic [2*COORD_BITS+3:0] mag [3];
    longint unsigned c [3];
    longint unsigned sum, root, n;
    int msb;
    comp_t o [3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = $signed(t.v[3+i]) - $signed(t.v[i]);
      e2[i] = $signed(t.v[6+i]) - $signed(t.v[i]);
    end
    cr[0] = e2[1] * e1[2] - e2[2] * e1[1];
    cr[1] = e2[2] * e1[0] - e2[0] * e1[2];
    cr[2] = e2[0] * e1[1] - e2[1] * e1[0];
    msb = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      for (int b = 0; b < 2*COORD_BITS+4; b++)
        if (mag[i][b] && b + 1 > msb) msb = b + 1;
    end
    res.degenerate = (msb == 0);
    res.nx = '0;
    res.ny = '0;
    res.nz = '0;
    if (msb == 0) return res;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (msb <= 31) c[i] = 64'(mag[i]) << (31 - msb);
      else c[i] = 64'(mag[i] >> (msb - 31));
      sum += c[i] * c[i];
    end
    root = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      n = ((c[i] << FRAC_BITS) * 2 + root) / (2 * root);
      if (cr[i] < 0) n = -n;
      o[i] = n[NORMAL_BITS-1:0];
    end
    res.nx = o[0];
    res.ny = o[1];
    res.nz = o[2];
    return res;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? coord_t'(-8388608) : coord_t'(8388607);
      1: return coord_t'($signed($urandom_range(0, 64)) - 32);
      2: return coord_t'($signed($urandom_range(0, 65535)) - 32768);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Queue one triangle for the sender.
  task automatic add_triangle(triangle_t t);
    pending_tris = {pending_tris, t};
  endtask

  // Sender: one transfer per item after a random gap.
  int send_gap = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      tri_in.valid <= 1'b0;
    end else if (tri_in.valid && !tri_in.ready) begin
      // Hold the item until the transfer completes.
    end else begin
      if (tri_in.valid) void'(pending_tris.pop_front());
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        tri_in.valid <= 1'b0;
      end else if (hold_sender && expected_normals.size() > 0) begin
        tri_in.valid <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        triangle_t t;
        t = pending_tris[0];
        tri_in.valid <= 1'b1;
        {tri_in.v0_x, tri_in.v0_y, tri_in.v0_z} <= {t.v[0], t.v[1], t.v[2]};
        {tri_in.v1_x, tri_in.v1_y, tri_in.v1_z} <= {t.v[3], t.v[4], t.v[5]};
        {tri_in.v2_x, tri_in.v2_y, tri_in.v2_z} <= {t.v[6], t.v[7], t.v[8]};
        expected_normals = {expected_normals, face_normal(t)};
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end else begin
        tri_in.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, compare each transfer with the oldest expectation.
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      norm_out.ready <= 1'b0;
    end else begin
      if (norm_out.valid && norm_out.ready) begin
        if (expected_normals.size() == 0) begin
          $error("unexpected normal transfer");
          fail_count = fail_count + 1;
        end else begin
          face_normal_t e;
          e = expected_normals.pop_front();
          if (norm_out.normal_x !== e.nx) begin
            $error("normal_x expected %0d actual %0d", e.nx, norm_out.normal_x);
            fail_count = fail_count + 1;
          end
          if (norm_out.normal_y !== e.ny) begin
            $error("normal_y expected %0d actual %0d", e.ny, norm_out.normal_y);
            fail_count = fail_count + 1;
          end
          if (norm_out.normal_z !== e.nz) begin
            $error("normal_z expected %0d actual %0d", e.nz, norm_out.normal_z);
            fail_count = fail_count + 1;
          end
          if (norm_out.degenerate !== e.degenerate) begin
            $error("degenerate expected %0b actual %0b", e.degenerate,
                   norm_out.degenerate);
            fail_count = fail_count + 1;
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        norm_out.ready <= 1'b0;
      end else begin
        norm_out.ready <= 1'b1;
        if (cycle_count > 60000 && cycle_count < 90000) stall <= 0;
        else stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end
    end
  end

  // Stimulus, end of run and timeout.
  initial begin
    triangle_t t;
    tri_in.valid = 1'b0;
    {tri_in.v0_x, tri_in.v0_y, tri_in.v0_z} = '0;
    {tri_in.v1_x, tri_in.v1_y, tri_in.v1_z} = '0;
    {tri_in.v2_x, tri_in.v2_y, tri_in.v2_z} = '0;
    norm_out.ready = 1'b0;

    // Directed: axis-aligned faces, both winding orders, extreme coordinates.
    for (int k = 0; k < 3; k++) begin
      foreach (t.v[i]) t.v[i] = '0;
      t.v[3 + (k + 1) % 3] = 24'sd4096;
      t.v[6 + (k + 2) % 3] = 24'sd4096;
      add_triangle(t);
      t.v[3 + (k + 1) % 3] = '0;
      t.v[6 + (k + 2) % 3] = '0;
      t.v[3 + (k + 2) % 3] = 24'sd4096;
      t.v[6 + (k + 1) % 3] = 24'sd4096;
      add_triangle(t);
    end
    // Zero-area triangles: all equal, collinear, two equal vertices.
    foreach (t.v[i]) t.v[i] = 24'sd1234;
    add_triangle(t);
    foreach (t.v[i]) t.v[i] = coord_t'(i / 3 * 100);
    add_triangle(t);
    foreach (t.v[i]) t.v[i] = (i < 6) ? coord_t'(i * 7) : coord_t'(i * 91);
    for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];
    add_triangle(t);
    // Extreme coordinates giving the widest cross product, then a unit face and a random one.
    foreach (t.v[i]) t.v[i] = coord_t'(-8388608);
    t.v[3] = 24'sd8388607; t.v[7] = 24'sd8388607;
    add_triangle(t);
    t.v[5] = 24'sd8388607; t.v[6] = 24'sd8388607; t.v[8] = 24'sd8388607;
    add_triangle(t);
    foreach (t.v[i]) t.v[i] = (i % 2) ? coord_t'(-8388608) : coord_t'(8388607);
    add_triangle(t);
    foreach (t.v[i]) t.v[i] = coord_t'(i == 4 || i == 8);
    add_triangle(t);
    foreach (t.v[i]) t.v[i] = coord_t'($urandom);
    add_triangle(t);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < RANDOM_TRIS; n++) begin
      int shape;
      shape = $urandom_range(0, 9);
      foreach (t.v[i]) t.v[i] = random_coord();
      // A few degenerate shapes among the random ones.
      if (shape == 0) for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
      if (shape == 1) for (int i = 0; i < 3; i++) t.v[6+i] = t.v[i] + 2 * (t.v[3+i] - t.v[i]);
      // Small triangles near a random point.
      if (shape == 2) for (int i = 3; i < 9; i++) t.v[i] = t.v[i%3] + coord_t'($urandom_range(0, 6)) - 3;
      add_triangle(t);
      if (n == RANDOM_TRIS / 2) begin
        wait (pending_tris.size() == 0);
        hold_sender = 1'b1;
        wait (expected_normals.size() == 0);
        hold_sender = 1'b0;
      end
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done && pending_tris.size() == 0 && expected_normals.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && expected_normals.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[triangle_face_normal_unit.f]
rtl/core/tfn_pkg.sv
rtl/core/tfn_tri_if.sv
rtl/core/tfn_norm_if.sv
rtl/core/triangle_face_normal_unit.sv
rtl/core/tfn_checker.sv
dv/triangle_face_normal_unit_test.sv
